// ===== rtl/core/dcls_pkg.sv =====
// shared constants, table codes and word types for the location sampler
package dcls_pkg;

  localparam int NUM_TYPES  = 16;
  localparam int CHILD_ROWS = 8;

  localparam int TYPE_AW = $clog2(NUM_TYPES);
  localparam int CDF_AW  = $clog2(CHILD_ROWS);
  localparam int ROW_W   = (TYPE_AW > CDF_AW) ? TYPE_AW : CDF_AW;

  localparam int PROB_W  = 33;
  localparam int CNT_W   = 16;
  localparam int OFF_W   = 32;
  localparam int Y_W     = 32;
  localparam int TYPE_W  = 4;
  localparam int AGE_W   = 3;
  localparam int PROD_W  = Y_W + CNT_W;
  localparam int BITC_W  = $clog2(CNT_W);

  localparam logic [1:0] TBL_PROB = 2'd0;
  localparam logic [1:0] TBL_CDF  = 2'd1;
  localparam logic [1:0] TBL_CNT  = 2'd2;
  localparam logic [1:0] TBL_OFF  = 2'd3;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [CNT_W-1:0]  cnt;
    logic [OFF_W-1:0]  off;
  } dcls_tword_t;

  typedef struct packed {
    logic [Y_W-1:0]    resid;
    logic [PROB_W-1:0] width;
    logic [CNT_W-1:0]  cnt;
    logic [OFF_W-1:0]  off;
  } dcls_bucket_t;

endpackage

// ===== rtl/core/dcls_div.sv =====
// bucket pick: multiply residual by count, divide by width, clamp and add offset
module dcls_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  dcls_pkg::dcls_bucket_t      bucket,
  output logic                        done,
  output logic [dcls_pkg::OFF_W-1:0]  loc
);

  logic                          running;
  logic [dcls_pkg::PROB_W-1:0]   rem;
  logic [dcls_pkg::CNT_W-1:0]    plo;
  logic [dcls_pkg::CNT_W-1:0]    quo;
  logic [dcls_pkg::BITC_W-1:0]   bitc;

  logic [dcls_pkg::PROD_W-1:0]   prod;
  logic [dcls_pkg::PROB_W:0]     trial;
  logic [dcls_pkg::PROB_W:0]     diff;
  logic                          ge;
  logic [dcls_pkg::CNT_W-1:0]    quo_next;
  logic                          zero_case;
  logic                          clamp_case;

  always_comb begin
    prod       = dcls_pkg::PROD_W'(bucket.resid) * dcls_pkg::PROD_W'(bucket.cnt);
    zero_case  = (bucket.width == '0) || (bucket.cnt == '0);
    clamp_case = ({1'b0, bucket.resid} >= bucket.width);
    trial      = {rem, plo[dcls_pkg::CNT_W-1]};
    diff       = trial - {1'b0, bucket.width};
    ge         = (trial >= {1'b0, bucket.width});
    quo_next   = {quo[dcls_pkg::CNT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        if (zero_case) begin
          done <= 1'b1;
          loc  <= bucket.off;
        end else if (clamp_case) begin
          done <= 1'b1;
          loc  <= dcls_pkg::OFF_W'(bucket.cnt - dcls_pkg::CNT_W'(1)) + bucket.off;
        end else begin
          running <= 1'b1;
          rem     <= {1'b0, prod[dcls_pkg::PROD_W-1:dcls_pkg::CNT_W]};
          plo     <= prod[dcls_pkg::CNT_W-1:0];
          quo     <= '0;
          bitc    <= dcls_pkg::BITC_W'(dcls_pkg::CNT_W - 1);
        end
      end else if (running) begin
        rem  <= ge ? diff[dcls_pkg::PROB_W-1:0] : trial[dcls_pkg::PROB_W-1:0];
        plo  <= {plo[dcls_pkg::CNT_W-2:0], 1'b0};
        quo  <= quo_next;
        bitc <= bitc - dcls_pkg::BITC_W'(1);
        if (bitc == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
          loc     <= dcls_pkg::OFF_W'(quo_next) + bucket.off;
        end
      end
    end
  end

endmodule

// ===== rtl/core/discrete_cdf_location_sampler_top.sv =====
// location sampler top: table memories, cdf walk control and result port
// table write: no result, busy stays low
// sample: adult walks type rows; child walks cdf rows, then reads the type row in S_CREAD;
// both then start the divider in S_GO and wait in S_WAIT; the divider skips its bit loop when
// width or count is zero or the pick clamps. one item at a time, one table row a cycle,
// divider one bit; results are not held off. reset clears control and first_school_type
module discrete_cdf_location_sampler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [1:0]  table_id,
  input  logic [3:0]  table_index,
  input  logic [32:0] table_value,
  input  logic [31:0] random_word,
  input  logic        is_adult,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [31:0] location_id,
  output logic [3:0]  business_type,
  output logic [2:0]  age_group,
  output logic        adult_out
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AWALK = 3'd1;
  localparam logic [2:0] S_CWALK = 3'd2;
  localparam logic [2:0] S_CREAD = 3'd3;
  localparam logic [2:0] S_GO    = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  logic [2:0]                         state;
  logic [3:0]                         first_school_type;
  logic [dcls_pkg::ROW_W-1:0]         row;
  logic [dcls_pkg::Y_W-1:0]           y;
  logic [dcls_pkg::PROB_W-1:0]        lo;
  logic                               adult;
  logic [dcls_pkg::TYPE_W-1:0]        btype;
  logic [dcls_pkg::AGE_W-1:0]         age;
  dcls_pkg::dcls_bucket_t             bucket;

  dcls_pkg::dcls_tword_t              tmem [dcls_pkg::NUM_TYPES];
  logic [dcls_pkg::PROB_W-1:0]        cmem [dcls_pkg::CHILD_ROWS];
  dcls_pkg::dcls_tword_t              t_rd;
  logic [dcls_pkg::PROB_W-1:0]        c_rd;
  logic [dcls_pkg::TYPE_AW-1:0]       t_raddr;
  logic [dcls_pkg::CDF_AW-1:0]        c_raddr;

  logic                               accept;
  logic                               wr_en;
  logic                               a_cont;
  logic                               c_cont;
  logic [dcls_pkg::TYPE_W-1:0]        school;
  logic                               type_ok;
  logic                               go;
  logic                               div_done;
  logic [dcls_pkg::OFF_W-1:0]         div_loc;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_en     = accept && (func == dcls_pkg::FUNC_WRITE);
  assign go        = (state == S_GO);

  always_comb begin
    a_cont  = (row < dcls_pkg::ROW_W'(dcls_pkg::NUM_TYPES - 1)) && (t_rd.prob < {1'b0, y});
    c_cont  = (row < dcls_pkg::ROW_W'(dcls_pkg::CHILD_ROWS - 1)) && ({1'b0, y} > c_rd);
    school  = dcls_pkg::TYPE_W'(row) + first_school_type;
    type_ok = (32'(btype) < dcls_pkg::NUM_TYPES);
    t_raddr = '0;
    c_raddr = '0;
    unique case (state)
      S_AWALK: begin
        t_raddr = a_cont ? dcls_pkg::TYPE_AW'(row + dcls_pkg::ROW_W'(1))
                         : dcls_pkg::TYPE_AW'(row);
      end
      S_CWALK: begin
        t_raddr = dcls_pkg::TYPE_AW'(school);
        c_raddr = c_cont ? dcls_pkg::CDF_AW'(row + dcls_pkg::ROW_W'(1))
                         : dcls_pkg::CDF_AW'(row);
      end
      default: begin
        t_raddr = '0;
        c_raddr = '0;
      end
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (table_id)
        dcls_pkg::TBL_PROB: begin
          if (32'(table_index) < dcls_pkg::NUM_TYPES) begin
            tmem[dcls_pkg::TYPE_AW'(table_index)].prob <= table_value;
          end
        end
        dcls_pkg::TBL_CDF: begin
          if (32'(table_index) < dcls_pkg::CHILD_ROWS) begin
            cmem[dcls_pkg::CDF_AW'(table_index)] <= table_value;
          end
        end
        dcls_pkg::TBL_CNT: begin
          if (32'(table_index) < dcls_pkg::NUM_TYPES) begin
            tmem[dcls_pkg::TYPE_AW'(table_index)].cnt <= table_value[dcls_pkg::CNT_W-1:0];
          end
        end
        default: begin
          if (32'(table_index) < dcls_pkg::NUM_TYPES) begin
            tmem[dcls_pkg::TYPE_AW'(table_index)].off <= table_value[dcls_pkg::OFF_W-1:0];
          end
        end
      endcase
    end
    t_rd <= tmem[t_raddr];
    c_rd <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      first_school_type <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        first_school_type <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (func == dcls_pkg::FUNC_SAMPLE)) begin
            y     <= random_word;
            adult <= is_adult;
            row   <= '0;
            lo    <= '0;
            state <= is_adult ? S_AWALK : S_CWALK;
          end
        end
        S_AWALK: begin
          if (a_cont) begin
            y   <= y - t_rd.prob[dcls_pkg::Y_W-1:0];
            row <= row + dcls_pkg::ROW_W'(1);
          end else begin
            btype        <= dcls_pkg::TYPE_W'(row);
            age          <= '0;
            bucket.resid <= y;
            bucket.width <= t_rd.prob;
            bucket.cnt   <= t_rd.cnt;
            bucket.off   <= t_rd.off;
            state        <= S_GO;
          end
        end
        S_CWALK: begin
          if (c_cont) begin
            lo  <= c_rd;
            row <= row + dcls_pkg::ROW_W'(1);
          end else begin
            btype        <= school;
            age          <= dcls_pkg::AGE_W'(row);
            bucket.width <= (c_rd > lo) ? c_rd - lo : '0;
            bucket.resid <= ({1'b0, y} > lo) ? y - lo[dcls_pkg::Y_W-1:0] : '0;
            state        <= S_CREAD;
          end
        end
        S_CREAD: begin
          bucket.cnt <= type_ok ? t_rd.cnt : '0;
          bucket.off <= type_ok ? t_rd.off : '0;
          state      <= S_GO;
        end
        S_GO: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dcls_div u_div (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .bucket (bucket),
    .done   (div_done),
    .loc    (div_loc)
  );

  assign done          = div_done;
  assign location_id   = div_loc;
  assign business_type = btype;
  assign age_group     = age;
  assign adult_out     = adult;

endmodule
